@@ rtl/tlpq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the two-level priority queue.
// No dependencies; every other file imports this package.
package tlpq_pkg;

  // Operation codes of an input beat
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Queue selection
  localparam logic PRIO_HIGH = 1'b0;
  localparam logic PRIO_LOW  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  localparam int unsigned FILL_W = 5;

  typedef struct packed {
    logic        op;
    logic [15:0] req_id;
    logic        req_priority;
    logic [31:0] req_payload;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       served_id;
    logic              served_priority;
    logic [31:0]       served_payload;
    logic              next_valid;
    logic [15:0]       next_id;
    logic              next_priority;
    logic [FILL_W-1:0] high_fill;
    logic [FILL_W-1:0] low_fill;
  } out_t;

  // One stored request
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] payload;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PEEK,
    ST_RESP
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;    // take the input beat
    logic exec;     // perform push or pop on the rings
    logic capture;  // register the popped entry
  } dp_cmd_t;

endpackage

@@ rtl/tlpq_ring.sv @@
`timescale 1ns / 1ps
// One bounded FIFO ring: entry memory, head/tail pointers and fill count.
// Depends on tlpq_pkg for the entry type.
module tlpq_ring #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              pop_i,
  input  tlpq_pkg::entry_t  wdata_i,
  output tlpq_pkg::entry_t  rdata_o,
  output logic              empty_o,
  output logic              full_o,
  output logic [CNT_W-1:0]  count_o
);
  import tlpq_pkg::*;

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  // write at tail; read port always follows the head
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= wdata_i;
    end
    rdata_q <= mem_q[head_q];
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d = (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
    end
    if (pop_i) begin
      head_d = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign rdata_o = rdata_q;
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == FULL_CNT);
  assign count_o = count_q;

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full ring");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty ring");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("ring fill count beyond depth");

endmodule

@@ rtl/tlpq_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: input register, the two rings, served-entry registers, result assembly.
// Depends on tlpq_pkg and tlpq_ring.
module tlpq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlpq_pkg::dp_cmd_t cmd_i,
  input  tlpq_pkg::in_t     req_i,
  output tlpq_pkg::out_t    res_o
);
  import tlpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  in_t              req_q;
  logic [1:0]       status_q, status_d;
  logic             src_q, src_d;      // ring the pop is served from
  logic             hit_q, hit_d;      // pop found an entry
  entry_t           served_q;

  logic             hi_push, hi_pop, lo_push, lo_pop;
  logic             hi_empty, hi_full, lo_empty, lo_full;
  entry_t           hi_rdata, lo_rdata, wdata;
  logic [CNT_W-1:0] hi_count, lo_count;

  assign wdata = '{id: req_q.req_id, payload: req_q.req_payload};

  // decode of the held beat against the ring flags
  always_comb begin
    hi_push  = 1'b0;
    lo_push  = 1'b0;
    hi_pop   = 1'b0;
    lo_pop   = 1'b0;
    status_d = STATUS_DONE;
    src_d    = PRIO_HIGH;
    hit_d    = 1'b0;
    if (req_q.op == OP_PUSH) begin
      if (req_q.req_priority == PRIO_LOW) begin
        if (lo_full) status_d = STATUS_FULL;
        else         lo_push  = cmd_i.exec;
      end else begin
        if (hi_full) status_d = STATUS_FULL;
        else         hi_push  = cmd_i.exec;
      end
    end else begin
      if (!hi_empty) begin
        hi_pop = cmd_i.exec;
        hit_d  = 1'b1;
      end else if (!lo_empty) begin
        lo_pop = cmd_i.exec;
        src_d  = PRIO_LOW;
        hit_d  = 1'b1;
      end else begin
        status_d = STATUS_EMPTY;
      end
    end
  end

  tlpq_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_high (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (hi_push),
    .pop_i   (hi_pop),
    .wdata_i (wdata),
    .rdata_o (hi_rdata),
    .empty_o (hi_empty),
    .full_o  (hi_full),
    .count_o (hi_count)
  );

  tlpq_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_low (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (lo_push),
    .pop_i   (lo_pop),
    .wdata_i (wdata),
    .rdata_o (lo_rdata),
    .empty_o (lo_empty),
    .full_o  (lo_full),
    .count_o (lo_count)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      src_q    <= src_d;
      hit_q    <= hit_d;
    end
    // read data in the cycle after exec is the old head of the served ring
    if (cmd_i.capture) begin
      if (!hit_q)                  served_q <= '0;
      else if (src_q == PRIO_LOW)  served_q <= lo_rdata;
      else                         served_q <= hi_rdata;
    end
  end

  // by the response cycle the read registers hold the new heads
  always_comb begin
    res_o                 = '0;
    res_o.status          = status_q;
    res_o.served_id       = served_q.id;
    res_o.served_payload  = served_q.payload;
    res_o.served_priority = hit_q ? src_q : PRIO_HIGH;
    res_o.high_fill       = FILL_W'(hi_count);
    res_o.low_fill        = FILL_W'(lo_count);
    if (!hi_empty) begin
      res_o.next_valid    = 1'b1;
      res_o.next_id       = hi_rdata.id;
      res_o.next_priority = PRIO_HIGH;
    end else if (!lo_empty) begin
      res_o.next_valid    = 1'b1;
      res_o.next_id       = lo_rdata.id;
      res_o.next_priority = PRIO_LOW;
    end
  end

endmodule

@@ rtl/tlpq_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: steps each beat through exec, peek and response cycles.
// Depends on tlpq_pkg for the state and command types.
module tlpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output tlpq_pkg::dp_cmd_t cmd_o
);
  import tlpq_pkg::*;

  state_e state_q, state_d;
  logic   take;

  assign take = start && !busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_PEEK;
      ST_PEEK: state_d = ST_RESP;
      ST_RESP: begin
        state_d = take ? ST_EXEC : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state_q == ST_EXEC) || (state_q == ST_PEEK);
    done_o        = (state_q == ST_RESP);
    cmd_o.latch   = take;
    cmd_o.exec    = (state_q == ST_EXEC);
    cmd_o.capture = (state_q == ST_PEEK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/two_level_priority_queue_unit.sv @@
`timescale 1ns / 1ps
// Top level of the two-level strict-priority request queue.
// Depends on tlpq_pkg, tlpq_ctrl, tlpq_datapath (and tlpq_ring below it).
//
//   channel  | ports                  | handshake
//   ---------+------------------------+-----------------------------------
//   request  | req_i (in_t)           | beat taken when start && !busy
//   result   | res_o (out_t)          | one cycle, marked by done_o
//
// Each beat steps through exec (ring update and head read), peek
// (popped entry captured, new head read) and response. The registered
// memory read port of each ring is why the peek step is needed. A new
// beat may be taken in the response cycle, but not in exec or peek.
// Reset clears pointers, fill counts and the sequencer; entry memories are
// not cleared. The result is shown for exactly one cycle and cannot stall.
module two_level_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tlpq_pkg::in_t  req_i,
  output logic           done_o,
  output tlpq_pkg::out_t res_o
);
  import tlpq_pkg::*;

  dp_cmd_t cmd;

  // sequencer: owns the handshake and times the datapath
  tlpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // datapath: both rings and the result registers
  tlpq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .res_o  (res_o)
  );

  // a taken beat always makes the unit busy next cycle
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("beat taken but unit not busy");

  // one result per beat: never two strobes in a row
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held over two cycles");

  // result in the response step, after exec and peek
  a_done_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> ##1 done_o)
    else $error("result strobe out of step with exec");

endmodule
